// ----- rtl/irn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package irn_pkg;

	localparam int MAX_WIDTH      = 256;
	localparam int MAX_HEIGHT     = 256;
	localparam int TRIG_FRAC_BITS = 14;

	localparam int XW      = $clog2(MAX_WIDTH);
	localparam int YW      = $clog2(MAX_HEIGHT);
	localparam int AW      = XW + YW;
	localparam int PIX_W   = 24;
	localparam int DIM_W   = 9;
	localparam int TRIG_W  = 16;
	localparam int SIZE_W  = 10;
	localparam int OFS_W   = 11;
	localparam int NUM_REGS = 4;
	localparam int PADDR_W = $clog2(4 * NUM_REGS);
	localparam int PDATA_W = 32;

	localparam int GW     = 27;
	localparam int RQW    = GW - TRIG_FRAC_BITS;
	localparam int MAP_GW = 12;
	localparam int MAP_PW = MAP_GW + TRIG_W;
	localparam int MAP_SW = MAP_PW + 1;
	localparam int MAP_QW = MAP_SW - TRIG_FRAC_BITS;

	localparam int TRIG_ONE = 1 << TRIG_FRAC_BITS;

	localparam logic signed [TRIG_W-1:0] TRIG_POS = TRIG_W'(TRIG_ONE);
	localparam logic signed [TRIG_W-1:0] TRIG_NEG = -TRIG_POS;
	localparam logic signed [GW-1:0] G_HALF = GW'(TRIG_ONE / 2);
	localparam logic [TRIG_FRAC_BITS-1:0] FRAC_HALF = TRIG_FRAC_BITS'(TRIG_ONE / 2);
	localparam logic signed [RQW-1:0] SIZE_MAX = RQW'((1 << SIZE_W) - 1);
	localparam logic signed [RQW-1:0] SIZE_MIN = RQW'(1);

	localparam logic [DIM_W-1:0] SRC_WIDTH_RST  = DIM_W'(256);
	localparam logic [DIM_W-1:0] SRC_HEIGHT_RST = DIM_W'(256);
	localparam logic signed [TRIG_W-1:0] COS_RST = TRIG_POS;
	localparam logic signed [TRIG_W-1:0] SIN_RST = '0;

	typedef enum logic [1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_COS        = 2'd2,
		REG_SIN        = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [SIZE_W-1:0]       rw;
		logic [SIZE_W-1:0]       rh;
		logic signed [OFS_W-1:0] ox;
		logic signed [OFS_W-1:0] oy;
	} geom_t;

	typedef struct packed {
		logic mul;
		logic addr;
	} map_ctl_t;

	typedef struct packed {
		logic          in_src;
		logic [AW-1:0] addr;
	} map_res_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int lim);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) r = DIM_W'(1);
		else if (int'(v) > lim) r = DIM_W'(lim);
		return r;
	endfunction

	function automatic logic signed [TRIG_W-1:0] trig_clamp(input logic signed [TRIG_W-1:0] v);
		logic signed [TRIG_W-1:0] r;
		r = v;
		if (v > TRIG_POS) r = TRIG_POS;
		else if (v < TRIG_NEG) r = TRIG_NEG;
		return r;
	endfunction

	function automatic logic signed [RQW-1:0] round_plus_half(input logic signed [GW-1:0] v);
		logic signed [GW-1:0] t;
		logic signed [GW-1:0] q;
		logic [TRIG_FRAC_BITS-1:0] fr;
		t  = v + G_HALF;
		q  = t >>> TRIG_FRAC_BITS;
		fr = t[TRIG_FRAC_BITS-1:0];
		if (fr > FRAC_HALF) q = q + GW'(1);
		else if (fr == FRAC_HALF) q = q + $signed({{(GW-1){1'b0}}, q[0]});
		return q[RQW-1:0];
	endfunction

	function automatic logic [SIZE_W-1:0] size_of(input logic signed [RQW-1:0] q);
		logic signed [RQW-1:0] n;
		n = q + SIZE_MIN;
		if (n > SIZE_MAX) n = SIZE_MAX;
		else if (n < SIZE_MIN) n = SIZE_MIN;
		return n[SIZE_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/irn_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module irn_store import irn_pkg::*; (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [PIX_W-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [PIX_W-1:0] rd_data
);

	logic [PIX_W-1:0] mem [0:(1 << AW)-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/irn_geom.sv -----
`timescale 1ns / 1ps
`default_nettype none

module irn_geom import irn_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [DIM_W-1:0]         w,
	input  wire logic [DIM_W-1:0]         h,
	input  wire logic signed [TRIG_W-1:0] c,
	input  wire logic signed [TRIG_W-1:0] s,
	output logic                          done,
	output geom_t                         geom
);

	typedef enum logic [3:0] {
		G_IDLE = 4'b0001,
		G_MUL  = 4'b0010,
		G_EXT  = 4'b0100,
		G_RND  = 4'b1000
	} gstate_t;

	gstate_t gstate_q;
	logic [1:0] step_q;
	logic signed [GW-1:0] prod_q [4];
	logic signed [GW-1:0] mnx_q, mxx_q, mny_q, mxy_q;

	logic [DIM_W-1:0] mul_a;
	logic signed [TRIG_W-1:0] mul_b;
	logic signed [GW-1:0] prod;
	logic signed [GW-1:0] x1, y1, y2;
	logic signed [RQW-1:0] q_w, q_h, q_ox, q_oy;

	function automatic logic signed [GW-1:0] min_z(input logic signed [GW-1:0] a,
			input logic signed [GW-1:0] b, input logic signed [GW-1:0] d);
		logic signed [GW-1:0] m;
		m = '0;
		if (a < m) m = a;
		if (b < m) m = b;
		if (d < m) m = d;
		return m;
	endfunction

	function automatic logic signed [GW-1:0] max_z(input logic signed [GW-1:0] a,
			input logic signed [GW-1:0] b, input logic signed [GW-1:0] d);
		logic signed [GW-1:0] m;
		m = '0;
		if (a > m) m = a;
		if (b > m) m = b;
		if (d > m) m = d;
		return m;
	endfunction

	// Product order: h*s, h*c, w*c, w*s.
	assign mul_a = step_q[1] ? w : h;
	assign mul_b = (step_q == 2'd0 || step_q == 2'd3) ? s : c;
	assign prod  = GW'($signed({1'b0, mul_a})) * GW'(mul_b);

	assign x1 = prod_q[2] + prod_q[0];
	assign y1 = prod_q[1] - prod_q[3];
	assign y2 = -prod_q[3];

	assign q_w  = round_plus_half(mxx_q - mnx_q);
	assign q_h  = round_plus_half(mxy_q - mny_q);
	assign q_ox = round_plus_half(mnx_q);
	assign q_oy = round_plus_half(mny_q);

	assign done = (gstate_q == G_RND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gstate_q <= G_IDLE;
			step_q   <= '0;
		end else begin
			unique case (gstate_q)
				G_IDLE: begin
					step_q <= '0;
					if (start) gstate_q <= G_MUL;
				end
				G_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) gstate_q <= G_EXT;
				end
				G_EXT: gstate_q <= G_RND;
				G_RND: gstate_q <= G_IDLE;
				default: gstate_q <= G_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (gstate_q == G_MUL) begin
			prod_q[step_q] <= prod;
		end
		if (gstate_q == G_EXT) begin
			mnx_q <= min_z(prod_q[0], x1, prod_q[2]);
			mxx_q <= max_z(prod_q[0], x1, prod_q[2]);
			mny_q <= min_z(prod_q[1], y1, y2);
			mxy_q <= max_z(prod_q[1], y1, y2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom <= '0;
		end else if (gstate_q == G_RND) begin
			geom.rw <= size_of(q_w);
			geom.rh <= size_of(q_h);
			geom.ox <= q_ox[OFS_W-1:0];
			geom.oy <= q_oy[OFS_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/irn_map.sv -----
`timescale 1ns / 1ps
`default_nettype none

module irn_map import irn_pkg::*; (
	input  wire logic                     clk,
	input  wire map_ctl_t                 ctl,
	input  wire logic signed [MAP_GW-1:0] gx,
	input  wire logic signed [MAP_GW-1:0] gy,
	input  wire logic signed [TRIG_W-1:0] c,
	input  wire logic signed [TRIG_W-1:0] s,
	input  wire logic [DIM_W-1:0]         w,
	input  wire logic [DIM_W-1:0]         h,
	output map_res_t                      res
);

	logic signed [MAP_PW-1:0] pxc_s2, pys_s2, pxs_s2, pyc_s2;
	logic signed [MAP_SW-1:0] sum_x, sum_y;
	logic signed [MAP_QW-1:0] sx, sy;

	function automatic logic signed [MAP_QW-1:0] trunc_q(input logic signed [MAP_SW-1:0] v);
		logic signed [MAP_SW-1:0] q;
		q = v >>> TRIG_FRAC_BITS;
		if (v[MAP_SW-1] && v[TRIG_FRAC_BITS-1:0] != '0) q = q + MAP_SW'(1);
		return q[MAP_QW-1:0];
	endfunction

	assign sum_x = MAP_SW'(pxc_s2) - MAP_SW'(pys_s2);
	assign sum_y = MAP_SW'(pxs_s2) + MAP_SW'(pyc_s2);
	assign sx = trunc_q(sum_x);
	assign sy = trunc_q(sum_y);

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			pxc_s2 <= MAP_PW'(gx) * MAP_PW'(c);
			pys_s2 <= MAP_PW'(gy) * MAP_PW'(s);
			pxs_s2 <= MAP_PW'(gx) * MAP_PW'(s);
			pyc_s2 <= MAP_PW'(gy) * MAP_PW'(c);
		end
		if (ctl.addr) begin
			res.in_src <= !sx[MAP_QW-1] && !sy[MAP_QW-1]
				&& (sx < $signed({{(MAP_QW-DIM_W){1'b0}}, w}))
				&& (sy < $signed({{(MAP_QW-DIM_W){1'b0}}, h}));
			res.addr <= {sy[YW-1:0], sx[XW-1:0]};
		end
	end

endmodule

`default_nettype wire

// ----- rtl/image_rotate_nearest_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A load request is taken while the unit is idle. The last load of a frame starts the
// bounding-box calculation, which holds off requests until it completes.
// A fetch request goes through the multiply, address and frame memory read steps, and
// its pixel is then registered at the output; a new request is taken only once the
// previous one is done; a stalled result holds off further requests until it is taken.
// Reset clears the counters, sizes and offsets and restores the default configuration.

module image_rotate_nearest_unit import irn_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic               operation,
	input  wire logic [7:0]         blue,
	input  wire logic [7:0]         green,
	input  wire logic [7:0]         red,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic      [7:0]         out_blue,
	output logic      [7:0]         out_green,
	output logic      [7:0]         out_red,
	output logic      [SIZE_W-1:0]  out_column,
	output logic      [SIZE_W-1:0]  out_line,
	output logic      [SIZE_W-1:0]  frame_width,
	output logic      [SIZE_W-1:0]  frame_height,
	output logic                    last_pixel
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_GEOM = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_ADDR = 6'b001000,
		ST_READ = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q;

	logic [DIM_W-1:0] src_width_q, src_height_q;
	logic signed [TRIG_W-1:0] cos_q, sin_q;
	logic [XW-1:0] load_x_q;
	logic [YW-1:0] load_y_q;
	logic [SIZE_W-1:0] emit_x_q, emit_y_q;
	logic [PIX_W-1:0] bg_q;
	logic loaded_q;

	logic [SIZE_W-1:0] col_q, line_q, fw_q, fh_q;
	logic last_q;
	logic signed [MAP_GW-1:0] gx_s1, gy_s1;
	logic res_valid_q;

	logic [DIM_W-1:0] eff_w, eff_h;
	logic signed [TRIG_W-1:0] c_eff, s_eff;
	logic cfg_wr;
	reg_idx_t cfg_idx;
	logic accept, load_acc, fetch_acc;
	logic [XW-1:0] lx;
	logic [YW-1:0] ly;
	logic row_end, col_end, frame_end;
	logic ex_end, ey_end;
	logic [PIX_W-1:0] px_in;
	logic geom_done;
	geom_t geom;
	map_ctl_t map_ctl;
	map_res_t map_res;
	logic [PIX_W-1:0] rd_data;
	logic [PIX_W-1:0] px_out;
	logic out_load;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (cfg_idx)
			REG_SRC_WIDTH:  prdata = PDATA_W'(src_width_q);
			REG_SRC_HEIGHT: prdata = PDATA_W'(src_height_q);
			REG_COS:        prdata = PDATA_W'($unsigned(cos_q));
			REG_SIN:        prdata = PDATA_W'($unsigned(sin_q));
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_WIDTH_RST;
			src_height_q <= SRC_HEIGHT_RST;
			cos_q        <= COS_RST;
			sin_q        <= SIN_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_SRC_WIDTH:  src_width_q  <= pwdata[DIM_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= pwdata[DIM_W-1:0];
				REG_COS:        cos_q        <= $signed(pwdata[TRIG_W-1:0]);
				REG_SIN:        sin_q        <= $signed(pwdata[TRIG_W-1:0]);
				default: ;
			endcase
		end
	end

	assign eff_w = eff_dim(src_width_q, MAX_WIDTH);
	assign eff_h = eff_dim(src_height_q, MAX_HEIGHT);
	assign c_eff = trig_clamp(cos_q);
	assign s_eff = trig_clamp(sin_q);

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign load_acc  = accept && !operation;
	assign fetch_acc = accept && operation && loaded_q;

	assign lx = ({1'b0, DIM_W'(load_x_q)} >= {1'b0, eff_w}) ? '0 : load_x_q;
	assign ly = ({1'b0, DIM_W'(load_y_q)} >= {1'b0, eff_h}) ? '0 : load_y_q;
	assign row_end   = ({1'b0, DIM_W'(lx)} + (DIM_W+1)'(1)) >= {1'b0, eff_w};
	assign col_end   = ({1'b0, DIM_W'(ly)} + (DIM_W+1)'(1)) >= {1'b0, eff_h};
	assign frame_end = row_end && col_end;
	assign px_in     = {red, green, blue};

	assign ex_end = ({1'b0, emit_x_q} + (SIZE_W+1)'(1)) >= {1'b0, geom.rw};
	assign ey_end = ({1'b0, emit_y_q} + (SIZE_W+1)'(1)) >= {1'b0, geom.rh};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			load_x_q <= '0;
			load_y_q <= '0;
			emit_x_q <= '0;
			emit_y_q <= '0;
			bg_q     <= '0;
			loaded_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (load_acc) begin
						if (lx == '0 && ly == '0) begin
							loaded_q <= 1'b0;
							emit_x_q <= '0;
							emit_y_q <= '0;
							bg_q     <= '0;
						end
						if (lx == XW'(2) && ly == YW'(2)) bg_q <= px_in;
						if (row_end) begin
							load_x_q <= '0;
							load_y_q <= col_end ? '0 : ly + YW'(1);
						end else begin
							load_x_q <= lx + XW'(1);
							load_y_q <= ly;
						end
						if (frame_end) state_q <= ST_GEOM;
					end else if (fetch_acc) begin
						if (ex_end) begin
							emit_x_q <= '0;
							emit_y_q <= ey_end ? '0 : emit_y_q + SIZE_W'(1);
						end else begin
							emit_x_q <= emit_x_q + SIZE_W'(1);
						end
						state_q <= ST_MUL;
					end
				end
				ST_GEOM: begin
					if (geom_done) begin
						loaded_q <= 1'b1;
						emit_x_q <= '0;
						emit_y_q <= '0;
						state_q  <= ST_IDLE;
					end
				end
				ST_MUL:  state_q <= ST_ADDR;
				ST_ADDR: state_q <= ST_READ;
				ST_READ: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fetch_acc) begin
			col_q  <= emit_x_q;
			line_q <= emit_y_q;
			fw_q   <= geom.rw;
			fh_q   <= geom.rh;
			last_q <= ex_end && ey_end;
			gx_s1  <= $signed({{(MAP_GW-SIZE_W){1'b0}}, emit_x_q}) + MAP_GW'(geom.ox);
			gy_s1  <= $signed({{(MAP_GW-SIZE_W){1'b0}}, emit_y_q}) + MAP_GW'(geom.oy);
		end
	end

	irn_geom u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (load_acc && frame_end),
		.w      (eff_w),
		.h      (eff_h),
		.c      (c_eff),
		.s      (s_eff),
		.done   (geom_done),
		.geom   (geom)
	);

	assign map_ctl.mul  = (state_q == ST_MUL);
	assign map_ctl.addr = (state_q == ST_ADDR);

	irn_map u_map (
		.clk (clk),
		.ctl (map_ctl),
		.gx  (gx_s1),
		.gy  (gy_s1),
		.c   (c_eff),
		.s   (s_eff),
		.w   (eff_w),
		.h   (eff_h),
		.res (map_res)
	);

	irn_store u_store (
		.clk     (clk),
		.wr_en   (load_acc),
		.wr_addr ({ly, lx}),
		.wr_data (px_in),
		.rd_en   (state_q == ST_READ),
		.rd_addr (map_res.addr),
		.rd_data (rd_data)
	);

	assign px_out   = map_res.in_src ? rd_data : bg_q;
	assign out_load = (state_q == ST_DONE) && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_blue     <= px_out[7:0];
			out_green    <= px_out[15:8];
			out_red      <= px_out[23:16];
			out_column   <= col_q;
			out_line     <= line_q;
			frame_width  <= fw_q;
			frame_height <= fh_q;
			last_pixel   <= last_q;
		end
	end

	assign res_valid = res_valid_q;

	a_map_needs_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> loaded_q)
		else $error("fetch pipeline started without a loaded frame");

	a_loaded_from_geom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(loaded_q) |-> $past(geom_done))
		else $error("frame marked loaded without bounding-box result");

	a_result_from_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the final fetch step");

	a_geom_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		geom_done |-> (state_q == ST_GEOM))
		else $error("bounding-box result arrived while not waiting for it");

endmodule

`default_nettype wire
